// ===== rtl/core/lfup_pkg.sv =====
// lfup_pkg: shared constants, types and controller states for the lfu page replacement block
package lfup_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int USES_BITS  = 16;
  localparam int FAULT_BITS = 32;
  localparam int CFG_BITS   = 5;
  localparam int SLOT_BITS  = 4;
  localparam int EVPG_BITS  = 16;
  localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

  // packed stream words, zero filled to whole bytes
  localparam int IN_RAW_W   = PAGE_BITS;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 1 + SLOT_BITS + 1 + EVPG_BITS + FAULT_BITS;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [CFG_BITS-1:0] FRAMES_RESET = CFG_BITS'(16);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // one frame table entry
  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [USES_BITS-1:0] uses;
  } frame_t;

  // one result word
  typedef struct packed {
    logic [FAULT_BITS-1:0] fault_total;
    logic [EVPG_BITS-1:0]  evicted_page;
    logic                  evicted_valid;
    logic [SLOT_BITS-1:0]  frame_slot;
    logic                  hit;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } lfup_state_e;

endpackage

// ===== rtl/core/lfu_page_replacement.sv =====
// lfu_page_replacement: frame table memory with a sequential match and minimum-count scan
// Each page is accepted in idle; the scan then reads the frame memory once per frame in use
// (1..16) and evaluates each registered read; write-back stores the frame and loads the result
// register, stalling while it is still full; the next page is taken only after write-back.
// A new word is accepted while the previous result still waits in the output register.
// Reset clears the fill pointer, fault counter and controller; frames_in_use resets to 16.
module lfu_page_replacement (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lfup_pkg::CFG_BITS-1:0]     cfg_wdata_i,   // frames_in_use
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [lfup_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,  // page
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // hit, frame_slot, evicted_valid, evicted_page, fault_total, zero fill
  output logic [lfup_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);
  import lfup_pkg::*;

  lfup_state_e state_q, state_d;

  logic [CFG_BITS-1:0]   frames_q;
  cnt_t                  n_act;
  cnt_t                  fill_q, fill_d;
  logic [FAULT_BITS-1:0] fault_q, fault_d;
  cnt_t                  cnt_q, cnt_d;
  logic [PAGE_BITS-1:0]  page_q;

  logic                  found_q, found_d;
  idx_t                  match_q, match_d;
  logic [USES_BITS-1:0]  match_uses_q, match_uses_d;
  idx_t                  best_q, best_d;
  logic [USES_BITS-1:0]  best_uses_q, best_uses_d;
  logic [PAGE_BITS-1:0]  best_page_q, best_page_d;

  frame_t                mem [MAX_FRAMES];
  frame_t                rd_q;
  logic                  rd_en;
  logic                  wr_en;
  idx_t                  wr_idx;
  frame_t                wr_data;

  idx_t                  eval_idx;
  logic                  eval_en;
  logic                  out_free;
  logic                  out_vld_q;
  result_t               out_q, res;
  idx_t                  slot;
  logic                  load_fill;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FRAMES_RESET;
    end else if (cfg_we_i) begin
      frames_q <= cfg_wdata_i;
    end
  end

  // frames in use, clamped to 1..MAX_FRAMES
  always_comb begin
    if (frames_q == '0) begin
      n_act = cnt_t'(1);
    end else if (CNT_W'(frames_q) > cnt_t'(MAX_FRAMES)) begin
      n_act = cnt_t'(MAX_FRAMES);
    end else begin
      n_act = CNT_W'(frames_q);
    end
  end

  // frame memory, one read and one write port
  assign rd_en = (state_q == ST_SCAN) && (cnt_q < n_act);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[cnt_q[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // scan pipeline: data for frame cnt-1 arrives while cnt is issued
  assign eval_en  = (state_q == ST_SCAN) && (cnt_q != '0);
  assign eval_idx = IDX_W'(cnt_q - cnt_t'(1));
  assign out_free = !out_vld_q || m_axis_tready_i;

  // slot and result for the write-back cycle
  assign load_fill = fill_q < n_act;
  always_comb begin
    if (found_q) begin
      slot = match_q;
    end else if (load_fill) begin
      slot = fill_q[IDX_W-1:0];
    end else begin
      slot = best_q;
    end
    res.hit           = found_q;
    res.frame_slot    = SLOT_BITS'(slot);
    res.evicted_valid = !found_q && !load_fill;
    res.evicted_page  = res.evicted_valid ? EVPG_BITS'(best_page_q) : '0;
    res.fault_total   = fault_d;
  end

  // controller and scan datapath
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    fill_d       = fill_q;
    fault_d      = fault_q;
    found_d      = found_q;
    match_d      = match_q;
    match_uses_d = match_uses_q;
    best_d       = best_q;
    best_uses_d  = best_uses_q;
    best_page_d  = best_page_q;
    wr_en        = 1'b0;
    wr_idx       = slot;
    wr_data      = '0;
    s_axis_tready_o = (state_q == ST_IDLE);

    if (!found_q && fault_q != '1) begin
      fault_d = fault_q + FAULT_BITS'(1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          found_d = 1'b0;
        end
        fault_d = fault_q;
      end
      ST_SCAN: begin
        fault_d = fault_q;
        if (eval_en) begin
          if (!found_q && (CNT_W'(eval_idx) < fill_q) && (rd_q.page == page_q)) begin
            found_d      = 1'b1;
            match_d      = eval_idx;
            match_uses_d = rd_q.uses;
          end
          if (eval_idx == '0 || rd_q.uses < best_uses_q) begin
            best_d      = eval_idx;
            best_uses_d = rd_q.uses;
            best_page_d = rd_q.page;
          end
        end
        if (cnt_q == n_act) begin
          state_d = ST_WRITE;
        end else begin
          cnt_d = cnt_q + cnt_t'(1);
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          wr_en        = 1'b1;
          wr_data.page = page_q;
          if (found_q) begin
            wr_data.uses = (match_uses_q == '1) ? match_uses_q
                                                : match_uses_q + USES_BITS'(1);
          end else begin
            wr_data.uses = USES_BITS'(1);
            if (load_fill) begin
              fill_d = fill_q + cnt_t'(1);
            end
          end
          state_d = ST_IDLE;
        end else begin
          fault_d = fault_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
        fault_d = fault_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      fill_q    <= '0;
      fault_q   <= '0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      fault_q <= fault_d;
      found_q <= found_d;
      if (state_q == ST_WRITE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      page_q <= s_axis_tdata_i[PAGE_BITS-1:0];
    end
    match_q      <= match_d;
    match_uses_q <= match_uses_d;
    best_q       <= best_d;
    best_uses_q  <= best_uses_d;
    best_page_q  <= best_page_d;
    if (state_q == ST_WRITE && out_free) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_q);

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cnt_t'(MAX_FRAMES))
    else $error("fill pointer beyond frame count");

  a_fault_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q >= $past(fault_q))
    else $error("fault counter went backwards");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.hit && out_q.evicted_valid))
    else $error("hit reported with an eviction");

  a_write_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (state_q == ST_IDLE) && out_vld_q)
    else $error("write-back without result word");

endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking stream testbench for the lfu page replacement block
`timescale 1ns / 100ps

module testbench;
  import lfup_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned RANDOM_WORDS = 1150;
  localparam int unsigned PRINT_CAP = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;  // page
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // hit, frame_slot, evicted_valid, evicted_page, fault_total, zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  lfu_page_replacement dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow frame table and counters
  logic [PAGE_BITS-1:0] res_page [MAX_FRAMES];
  logic [USES_BITS-1:0] res_uses [MAX_FRAMES];
  logic                 res_full [MAX_FRAMES];
  int unsigned          next_free;
  logic [FAULT_BITS-1:0] fault_count;
  logic [CFG_BITS-1:0]  frame_limit;

  logic [PAGE_BITS-1:0] page_q [$];
  result_t              expected_q [$];

  logic        send_idle_en = 1'b1;
  logic        recv_idle_en = 1'b1;
  logic        send_busy;
  int unsigned send_wait;
  int unsigned recv_wait;
  int unsigned recv_draw;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // lfu lookup and update of the shadow table, one referenced page
  function automatic result_t lfu_reference(input logic [PAGE_BITS-1:0] pg);
    result_t r;
    int unsigned n;
    int unsigned i;
    int unsigned pick;
    logic found;
    r = '0;
    found = 1'b0;
    pick = 0;
    n = 32'(frame_limit);
    if (n == 0) n = 1;
    else if (n > MAX_FRAMES) n = MAX_FRAMES;
    for (i = 0; i < n; i++) begin
      if (!found && res_full[i] && res_page[i] == pg) begin
        found = 1'b1;
        pick = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (res_uses[pick] != '1) res_uses[pick] = res_uses[pick] + USES_BITS'(1);
    end else begin
      if (next_free < n) begin
        pick = next_free;
        next_free++;
      end else begin
        // smallest count wins, lowest index on a tie
        for (i = 1; i < n; i++) begin
          if (res_uses[i] < res_uses[pick]) pick = i;
        end
        if (res_full[pick]) begin
          r.evicted_valid = 1'b1;
          r.evicted_page = res_page[pick];
        end
      end
      res_page[pick] = pg;
      res_uses[pick] = USES_BITS'(1);
      res_full[pick] = 1'b1;
      if (fault_count != '1) fault_count = fault_count + FAULT_BITS'(1);
    end
    r.frame_slot = pick[SLOT_BITS-1:0];
    r.fault_total = fault_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("word with none pending", got.fault_total, 32'd0);
    end else begin
      want = expected_q.pop_front();
      if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
      if (got.frame_slot !== want.frame_slot)
        report_mismatch("frame_slot", 32'(got.frame_slot), 32'(want.frame_slot));
      if (got.evicted_valid !== want.evicted_valid)
        report_mismatch("evicted_valid", 32'(got.evicted_valid), 32'(want.evicted_valid));
      if (got.evicted_page !== want.evicted_page)
        report_mismatch("evicted_page", 32'(got.evicted_page), 32'(want.evicted_page));
      if (got.fault_total !== want.fault_total)
        report_mismatch("fault_total", got.fault_total, want.fault_total);
    end
  endtask

  // input driver, one page word per handshake
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      send_wait <= 0;
    end else begin
      send_busy = s_axis_tvalid_i && !s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_q.push_back(lfu_reference(s_axis_tdata_i[PAGE_BITS-1:0]));
      if (!send_busy) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
        end else if (page_q.size() != 0) begin
          s_axis_tdata_i <= page_q.pop_front();
          send_busy = 1'b1;
          send_wait <= send_idle_en ? $urandom_range(0, 11) : 0;
        end
      end
      s_axis_tvalid_i <= send_busy;
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_wait <= 0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      check_result(result_t'(m_axis_tdata_o[OUT_RAW_W-1:0]));
      recv_draw = recv_idle_en ? $urandom_range(0, 11) : 0;
      m_axis_tready_i <= (recv_draw == 0);
      recv_wait <= recv_draw;
    end else if (!m_axis_tready_i) begin
      if (recv_wait <= 1) m_axis_tready_i <= 1'b1;
      else recv_wait <= recv_wait - 1;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // block is idle once every pushed page has come back as a result word
  task automatic wait_idle();
    @(negedge clk_i);
    while (page_q.size() != 0 || s_axis_tvalid_i || expected_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_frames(input logic [CFG_BITS-1:0] value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    frame_limit = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  logic [PAGE_BITS-1:0] pool [24];
  int unsigned pool_size;
  int unsigned phase_len;
  int unsigned issued;
  int unsigned pick_a;
  int unsigned pick_b;
  int unsigned roll;

  initial begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      res_page[k] = '0;
      res_uses[k] = '0;
      res_full[k] = 1'b0;
    end
    next_free = 0;
    fault_count = '0;
    frame_limit = FRAMES_RESET;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: page zero on an empty table, extremes, hits
    page_q.push_back(16'h0000);
    page_q.push_back(16'h0000);
    page_q.push_back(16'hFFFF);
    page_q.push_back(16'hFFFF);
    page_q.push_back(16'h5555);
    // single frame: hit, then replace it
    write_frames(5'd1);
    page_q.push_back(16'h0000);
    page_q.push_back(16'h1234);
    page_q.push_back(16'h1234);
    // zero frames behaves as one
    write_frames(5'd0);
    page_q.push_back(16'hAAAA);
    // above the maximum saturates, hidden frames come back
    write_frames(5'd31);
    page_q.push_back(16'hFFFF);
    page_q.push_back(16'h0001);
    page_q.push_back(16'h8000);
    // lowered count: tie on lowest count, then victim away from index zero
    write_frames(5'd3);
    page_q.push_back(16'h7FFF);
    page_q.push_back(16'h5555);
    page_q.push_back(16'h0F0F);
    page_q.push_back(16'h0F0F);
    page_q.push_back(16'h0F0F);
    page_q.push_back(16'h3C3C);
    // raised again: fill continues at the next empty frame
    write_frames(5'd17);
    page_q.push_back(16'h0001);
    page_q.push_back(16'hC3C3);

    // random phases over a skewed working set
    issued = 0;
    while (issued < RANDOM_WORDS) begin
      if (issued == 0) write_frames(5'd16);
      else if ($urandom_range(0, 3) == 0) write_frames(CFG_BITS'($urandom_range(0, 31)));
      else write_frames(CFG_BITS'($urandom_range(1, 16)));
      send_idle_en = ($urandom_range(0, 3) != 0);
      recv_idle_en = ($urandom_range(0, 3) != 0);
      pool_size = $urandom_range(1, 24);
      for (int k = 0; k < 24; k++) begin
        if ($urandom_range(0, 3) == 0) pool[k] = PAGE_BITS'($urandom_range(0, 31));
        else pool[k] = PAGE_BITS'($urandom);
      end
      phase_len = $urandom_range(20, 80);
      for (int k = 0; k < phase_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
          pick_a = $urandom_range(0, pool_size - 1);
          pick_b = $urandom_range(0, pool_size - 1);
          page_q.push_back(pool[(pick_a < pick_b) ? pick_a : pick_b]);
        end else if (roll < 93) begin
          page_q.push_back(PAGE_BITS'($urandom));
        end else begin
          page_q.push_back(($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF);
        end
      end
      issued += phase_len;
    end

    // drain and settle
    wait_idle();
    repeat (40) @(posedge clk_i);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
